### hw/rtl/ppab_pkg.sv
// shared types and constants of the pixel plot / alpha blend block
// no dependencies; imported by every module of the block
package ppab_pkg;

  // default framebuffer geometry
  localparam int unsigned MAX_WIDTH_DEF  = 256;
  localparam int unsigned MAX_HEIGHT_DEF = 256;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FORMAT = 2'd2;

  // operation codes; the unused code behaves as a read
  localparam logic [1:0] MODE_READ   = 2'd0;
  localparam logic [1:0] MODE_OPAQUE = 2'd1;
  localparam logic [1:0] MODE_BLEND  = 2'd2;

  // divide by 500 as multiply by reciprocal, exact for sums below 2^17
  localparam logic [18:0]  DIV500_MUL   = 19'd268436;
  localparam int unsigned  DIV500_SHIFT = 27;

  // one stored pixel, red in the low byte
  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  // input beat
  typedef struct packed {
    logic [1:0]         mode;
    logic signed [15:0] x_pos;
    logic signed [15:0] y_pos;
    logic [7:0]         red_in;
    logic [7:0]         green_in;
    logic [7:0]         blue_in;
    logic [7:0]         alpha_in;
  } in_beat_t;

  // result beat
  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic       clipped;
  } out_beat_t;

  // control from the sequencer to the blend datapath
  typedef struct packed {
    logic       load;
    logic [1:0] mode;
    logic       rgba;
  } blend_ctrl_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DONE
  } state_e;

endpackage

### hw/rtl/ppab_ram.sv
// pixel store: one write port, one read port, registered read data
// depends on ppab_pkg for the pixel word type
module ppab_ram
  import ppab_pkg::*;
#(
  parameter int unsigned ADDR_W = 16,
  parameter int unsigned DEPTH  = 65536
) (
  input  logic              clk_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output pixel_t            rd_data_o,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  pixel_t            wr_data_i
);

  pixel_t mem [DEPTH];
  pixel_t rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, registered on read enable
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### hw/rtl/ppab_blend.sv
// blend datapath: registered weighted sums, then constant division
// depends on ppab_pkg for pixel and control types and divider constants
module ppab_blend
  import ppab_pkg::*;
(
  input  logic        clk_i,
  input  blend_ctrl_t ctrl_i,
  input  pixel_t      old_i,
  input  pixel_t      colour_i,
  output pixel_t      word_o
);

  logic [16:0] sum_q [3];
  logic [16:0] sum_d [3];
  pixel_t      plain_q, plain_d;
  logic        blend_q;
  logic        rgba_q;
  logic [7:0]  alpha_q, alpha_d;
  logic [7:0]  old_c [3];
  logic [7:0]  new_c [3];
  logic [7:0]  res_c [3];
  logic [8:0]  alpha_sum;

  // weighted sum of old and new channel
  function automatic logic [16:0] wsum(input logic [7:0] old_v, input logic [7:0] w_old,
                                       input logic [7:0] new_v, input logic [7:0] w_new);
    logic [15:0] p_old;
    logic [15:0] p_new;
    p_old = 16'(old_v) * 16'(w_old);
    p_new = 16'(new_v) * 16'(w_new);
    return {1'b0, p_old} + {1'b0, p_new};
  endfunction

  // floor(v/255), exact for v below 65280
  function automatic logic [7:0] div255(input logic [16:0] v);
    logic [16:0] t;
    t = {1'b0, v[15:0]} + 17'd1 + 17'(v[15:8]);
    return t[15:8];
  endfunction

  // floor(v/500) keeping the low byte
  function automatic logic [7:0] div500(input logic [16:0] v);
    logic [35:0] p;
    p = 36'(v) * 36'(DIV500_MUL);
    return p[DIV500_SHIFT +: 8];
  endfunction

  assign old_c = '{old_i.red, old_i.green, old_i.blue};
  assign new_c = '{colour_i.red, colour_i.green, colour_i.blue};

  // first stage: products per channel and the non-blend word
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (ctrl_i.rgba) begin
        sum_d[i] = wsum(old_c[i], old_i.alpha, new_c[i], colour_i.alpha);
      end else begin
        sum_d[i] = wsum(old_c[i], 8'd255 - colour_i.alpha, new_c[i], colour_i.alpha);
      end
    end
    alpha_sum = {1'b0, old_i.alpha} + {1'b0, colour_i.alpha};
    alpha_d   = ctrl_i.rgba ? alpha_sum[8:1] : old_i.alpha;
    if (ctrl_i.mode == MODE_OPAQUE) begin
      plain_d       = colour_i;
      plain_d.alpha = ctrl_i.rgba ? 8'hFF : old_i.alpha;
    end else begin
      plain_d = old_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      sum_q   <= sum_d;
      plain_q <= plain_d;
      alpha_q <= alpha_d;
      blend_q <= (ctrl_i.mode == MODE_BLEND);
      rgba_q  <= ctrl_i.rgba;
    end
  end

  // second stage: divide and assemble
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      res_c[i] = rgba_q ? div500(sum_q[i]) : div255(sum_q[i]);
    end
    if (blend_q) begin
      word_o = '{alpha: alpha_q, blue: res_c[2], green: res_c[1], red: res_c[0]};
    end else begin
      word_o = plain_q;
    end
  end

endmodule

### hw/rtl/pixel_plot_alpha_blend.sv
// sequence: a taken input beat passes the read and done states; its result beat is
// registered on leaving done, which waits while a held result is stalled; no new input is taken
// until the sequence on the single pixel store ends; a waiting result does not block the next input
// reset: image 256 x 256, RGB format, output empty; pixel store is not cleared
// depends on ppab_pkg, ppab_ram and ppab_blend
module pixel_plot_alpha_blend
  import ppab_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_beat_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_beat_t             out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam logic [15:0] MaxW16 = 16'(MAX_WIDTH);
  localparam logic [15:0] MaxH16 = 16'(MAX_HEIGHT);

  state_e            state_q, state_d;
  logic [8:0]        width_q;
  logic [8:0]        height_q;
  logic              rgba_q;
  logic [1:0]        mode_q;
  pixel_t            colour_q;
  logic              clip_q;
  logic [AddrW-1:0]  addr_q;
  logic              out_valid_q;
  out_beat_t         out_data_q;
  logic              accept;
  logic              finish;
  logic              load;
  logic              in_image;
  logic [23:0]       addr_full;
  logic [AddrW-1:0]  addr;
  logic              wr_en;
  pixel_t            colour;
  pixel_t            old_word;
  pixel_t            new_word;
  blend_ctrl_t       ctrl;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 9'd256;
      height_q <= 9'd256;
      rgba_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IMAGE_WIDTH:  width_q  <= cfg_wdata_i;
        CFG_IMAGE_HEIGHT: height_q <= cfg_wdata_i;
        CFG_PIXEL_FORMAT: rgba_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // clipping and address of the incoming beat
  always_comb begin
    in_image = !in_data_i.x_pos[15] && !in_data_i.y_pos[15]
            && ({1'b0, in_data_i.x_pos[14:0]} < {7'b0, width_q})
            && ({1'b0, in_data_i.x_pos[14:0]} < MaxW16)
            && ({1'b0, in_data_i.y_pos[14:0]} < {7'b0, height_q})
            && ({1'b0, in_data_i.y_pos[14:0]} < MaxH16);
    addr_full = 24'(in_data_i.y_pos[11:0]) * 24'(MAX_WIDTH) + 24'(in_data_i.x_pos[11:0]);
    addr      = addr_full[AddrW-1:0];
    colour    = '{alpha: in_data_i.alpha_in, blue: in_data_i.blue_in,
                  green: in_data_i.green_in, red: in_data_i.red_in};
  end

  // sequencer: read, blend, write back
  always_comb begin
    state_d = state_q;
    accept  = 1'b0;
    load    = 1'b0;
    finish  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        accept = in_valid_i;
        if (in_valid_i) state_d = ST_READ;
      end
      ST_READ: begin
        load    = 1'b1;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          finish  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

  // item held while its pixel is in flight
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q   <= in_data_i.mode;
      colour_q <= colour;
      clip_q   <= !in_image;
      addr_q   <= addr;
    end
  end

  assign wr_en = finish && !clip_q && (mode_q == MODE_OPAQUE || mode_q == MODE_BLEND);

  ppab_ram #(
    .ADDR_W (AddrW),
    .DEPTH  (Depth)
  ) u_ram (
    .clk_i     (clk_i),
    .rd_en_i   (accept && in_image),
    .rd_addr_i (addr),
    .rd_data_o (old_word),
    .wr_en_i   (wr_en),
    .wr_addr_i (addr_q),
    .wr_data_i (new_word)
  );

  assign ctrl = '{load: load, mode: mode_q, rgba: rgba_q};

  ppab_blend u_blend (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .old_i    (old_word),
    .colour_i (colour_q),
    .word_o   (new_word)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      if (clip_q) begin
        out_data_q <= '{red_out: 8'd0, green_out: 8'd0, blue_out: 8'd0,
                        alpha_out: 8'd0, clipped: 1'b1};
      end else begin
        out_data_q <= '{red_out: new_word.red, green_out: new_word.green,
                        blue_out: new_word.blue, alpha_out: new_word.alpha,
                        clipped: 1'b0};
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### hw/rtl/ppab_checker.sv
// port-level checks of the pixel plot / alpha blend block, bound to the top level
// depends on ppab_pkg and pixel_plot_alpha_blend
module ppab_checker
  import ppab_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input in_beat_t              in_data_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input out_beat_t             out_data_o,
  input logic                  cfg_we_i,
  input logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // one beat at a time: busy right after an accepted beat
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again while a pixel is in flight");

  // a new result only appears while a beat was in flight
  a_result_from_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result beat without an input beat in flight");

  // clipped results carry a zero pixel
  a_clip_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.clipped |->
      out_data_o.red_out == 8'd0 && out_data_o.green_out == 8'd0 &&
      out_data_o.blue_out == 8'd0 && out_data_o.alpha_out == 8'd0)
    else $error("clipped result with non-zero pixel");

endmodule

bind pixel_plot_alpha_blend ppab_checker u_ppab_checker (.*);

### bench/tb_pixel_plot_alpha_blend.sv
// testbench of pixel_plot_alpha_blend: a directed table, then random pixel traffic in phases
// a result is the table's value or predicted from a framebuffer copy held here; needs ppab_pkg and the block rtl
module tb_pixel_plot_alpha_blend;
  timeunit 1ns;
  timeprecision 1ps;
  import ppab_pkg::*;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int RANDOM_PHASES   = 10;
  localparam int BEATS_PER_PHASE = 145;
  localparam int HOT_SPAN        = 6;
  localparam int N_DIRECTED      = 27;
  localparam int MAX_REPORTS     = 10;
  localparam int FRAME_WORDS     = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef enum logic {ROW_BEAT, ROW_REG} row_kind_e;
  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  typedef struct {
    row_kind_e              kind;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [CFG_DATA_W-1:0]  reg_val;
    in_beat_t               beat;
    bit                     known;
    out_beat_t              want;
  } plot_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  in_beat_t              in_data_i;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_beat_t             out_data_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  // framebuffer copy and register copy used for prediction
  pixel_t frame_copy [FRAME_WORDS];
  bit     frame_written [FRAME_WORDS];
  int     img_width  = 256;
  int     img_height = 256;
  bit     img_rgba   = 1'b0;

  out_beat_t plot_expect_q [$];
  plot_row_t directed_rows [N_DIRECTED];

  int phase_width  [RANDOM_PHASES] = '{256, 7, 1, 511, 0, 256, 3, 256, 200, 256};
  int phase_height [RANDOM_PHASES] = '{256, 5, 1, 511, 256, 0, 256, 2, 300, 256};
  int phase_format [RANDOM_PHASES] = '{1, 0, 1, 0, 1, 0, 1, 0, 1, 0};

  int send_gap_pct   = 0;
  int recv_stall_pct = 0;
  int last_x = 0;
  int last_y = 0;
  int cycle_count   = 0;
  int error_count   = 0;
  int beats_sent    = 0;
  int results_seen  = 0;
  int clipped_count = 0;
  int blend_count   = 0;
  int reg_writes    = 0;

  pixel_plot_alpha_blend uut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_data_i,
    .out_valid_o,
    .out_stall_i,
    .out_data_o,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver back-pressure
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycle_count,
               plot_expect_q.size());
      $display("[pixel_plot_alpha_blend] ERROR");
      $finish;
    end
  end

  // clipping against the configured size, capped at the store size
  function automatic bit inside_image(int xs, int ys);
    int wl, hl;
    wl = (img_width < MAX_WIDTH_DEF) ? img_width : MAX_WIDTH_DEF;
    hl = (img_height < MAX_HEIGHT_DEF) ? img_height : MAX_HEIGHT_DEF;
    return xs >= 0 && ys >= 0 && xs < wl && ys < hl;
  endfunction

  function automatic logic [7:0] mix_rgb(int o, int n, int a);
    return 8'((o * (255 - a) + n * a) / 255);
  endfunction

  // rgba rule keeps only the low byte of the quotient
  function automatic logic [7:0] mix_rgba(int o, int oa, int n, int a);
    return 8'((o * oa + n * a) / 500);
  endfunction

  // applies one beat to the framebuffer copy and returns the pixel it leaves
  function automatic out_beat_t plot_pixel(in_beat_t b);
    int        xs, ys, a, addr;
    pixel_t    px;
    out_beat_t res;
    xs  = $signed(b.x_pos);
    ys  = $signed(b.y_pos);
    res = '0;
    if (!inside_image(xs, ys)) begin
      res.clipped = 1'b1;
      return res;
    end
    addr = ys * MAX_WIDTH_DEF + xs;
    px   = frame_copy[addr];
    a    = b.alpha_in;
    case (b.mode)
      MODE_OPAQUE: begin
        px.red   = b.red_in;
        px.green = b.green_in;
        px.blue  = b.blue_in;
        if (img_rgba) px.alpha = 8'hff;
      end
      MODE_BLEND: begin
        if (img_rgba) begin
          px.red   = mix_rgba(px.red, px.alpha, b.red_in, a);
          px.green = mix_rgba(px.green, px.alpha, b.green_in, a);
          px.blue  = mix_rgba(px.blue, px.alpha, b.blue_in, a);
          px.alpha = 8'((px.alpha + a) / 2);
        end else begin
          px.red   = mix_rgb(px.red, b.red_in, a);
          px.green = mix_rgb(px.green, b.green_in, a);
          px.blue  = mix_rgb(px.blue, b.blue_in, a);
        end
      end
      default: ;
    endcase
    frame_copy[addr]    = px;
    frame_written[addr] = 1'b1;
    res.red_out   = px.red;
    res.green_out = px.green;
    res.blue_out  = px.blue;
    res.alpha_out = px.alpha;
    return res;
  endfunction

  // random beat: mostly a small hot corner and repeats of the last pixel, some clipped
  function automatic in_beat_t draw_plot_beat();
    in_beat_t b;
    int       wl, hl, xs, ys, pick, start, hx, hy;
    bit       found;
    wl = (img_width < MAX_WIDTH_DEF) ? img_width : MAX_WIDTH_DEF;
    hl = (img_height < MAX_HEIGHT_DEF) ? img_height : MAX_HEIGHT_DEF;
    b.red_in   = 8'($urandom);
    b.green_in = 8'($urandom);
    b.blue_in  = 8'($urandom);
    pick = $urandom_range(0, 9);
    b.alpha_in = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hff : 8'($urandom);
    pick = $urandom_range(0, 99);
    b.mode = (pick < 15) ? MODE_READ : (pick < 45) ? MODE_OPAQUE :
             (pick < 92) ? MODE_BLEND : MODE_UNUSED;
    pick = $urandom_range(0, 99);
    if (wl == 0 || hl == 0 || pick < 15) begin
      case ($urandom_range(0, 4))
        0: begin
          xs = -int'($urandom_range(1, 32768));
          ys = $urandom_range(0, 255);
        end
        1: begin
          xs = $urandom_range(0, 255);
          ys = -int'($urandom_range(1, 32768));
        end
        2: begin
          xs = wl + int'($urandom_range(0, 32767 - wl));
          ys = $urandom_range(0, 255);
        end
        3: begin
          xs = $urandom_range(0, 255);
          ys = hl + int'($urandom_range(0, 32767 - hl));
        end
        default: begin
          xs = $urandom_range(0, 1) ? 32767 : -32768;
          ys = $signed(16'($urandom));
        end
      endcase
    end else if (pick < 40) begin
      xs = last_x;
      ys = last_y;
    end else if (pick < 85) begin
      xs = $urandom_range(0, ((wl < HOT_SPAN) ? wl : HOT_SPAN) - 1);
      ys = $urandom_range(0, ((hl < HOT_SPAN) ? hl : HOT_SPAN) - 1);
    end else begin
      xs = $urandom_range(0, wl - 1);
      ys = $urandom_range(0, hl - 1);
    end
    // an unwritten pixel is only ever written, and only in rgba format where alpha is set
    if (inside_image(xs, ys) && !frame_written[ys * MAX_WIDTH_DEF + xs]) begin
      if (img_rgba) begin
        b.mode = MODE_OPAQUE;
      end else begin
        found = 1'b0;
        start = $urandom_range(0, HOT_SPAN * HOT_SPAN - 1);
        for (int i = 0; i < HOT_SPAN * HOT_SPAN && !found; i++) begin
          hx = (start + i) % HOT_SPAN;
          hy = ((start + i) / HOT_SPAN) % HOT_SPAN;
          if (inside_image(hx, hy) && frame_written[hy * MAX_WIDTH_DEF + hx]) begin
            xs    = hx;
            ys    = hy;
            found = 1'b1;
          end
        end
        if (!found) xs = -1;
      end
    end
    b.x_pos = 16'(xs);
    b.y_pos = 16'(ys);
    last_x  = xs;
    last_y  = ys;
    return b;
  endfunction

  // table row builders
  function automatic plot_row_t row_beat(logic [1:0] mode, int xs, int ys,
                                         int r, int g, int bl, int a);
    plot_row_t row;
    row.kind           = ROW_BEAT;
    row.reg_idx        = '0;
    row.reg_val        = '0;
    row.known          = 1'b0;
    row.want           = '0;
    row.beat.mode      = mode;
    row.beat.x_pos     = 16'(xs);
    row.beat.y_pos     = 16'(ys);
    row.beat.red_in    = 8'(r);
    row.beat.green_in  = 8'(g);
    row.beat.blue_in   = 8'(bl);
    row.beat.alpha_in  = 8'(a);
    return row;
  endfunction

  function automatic plot_row_t row_known(logic [1:0] mode, int xs, int ys,
                                          int r, int g, int bl, int a,
                                          int er, int eg, int eb, int ea);
    plot_row_t row;
    row = row_beat(mode, xs, ys, r, g, bl, a);
    row.known          = 1'b1;
    row.want.red_out   = 8'(er);
    row.want.green_out = 8'(eg);
    row.want.blue_out  = 8'(eb);
    row.want.alpha_out = 8'(ea);
    row.want.clipped   = 1'b0;
    return row;
  endfunction

  function automatic plot_row_t row_clip(logic [1:0] mode, int xs, int ys);
    plot_row_t row;
    row = row_beat(mode, xs, ys, 'hff, 'hff, 'hff, 'hff);
    row.known        = 1'b1;
    row.want         = '0;
    row.want.clipped = 1'b1;
    return row;
  endfunction

  function automatic plot_row_t row_reg(logic [CFG_IDX_W-1:0] idx, int value);
    plot_row_t row;
    row.kind    = ROW_REG;
    row.reg_idx = idx;
    row.reg_val = CFG_DATA_W'(value);
    row.beat    = '0;
    row.known   = 1'b0;
    row.want    = '0;
    return row;
  endfunction

  // offers one beat at the falling edge and holds it until taken
  task automatic send_plot_beat(in_beat_t b, bit known, out_beat_t want);
    out_beat_t got;
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    got = plot_pixel(b);
    plot_expect_q.push_back(known ? want : got);
    beats_sent++;
    if (got.clipped) clipped_count++;
    else if (b.mode == MODE_BLEND) blend_count++;
    @(negedge clk_i);
  endtask

  // stop offering beats and wait for every outstanding result
  task automatic wait_frame_idle();
    in_valid_i <= 1'b0;
    while (plot_expect_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= CFG_DATA_W'(value);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    case (idx)
      CFG_IMAGE_WIDTH:  img_width  = value & 'h1ff;
      CFG_IMAGE_HEIGHT: img_height = value & 'h1ff;
      CFG_PIXEL_FORMAT: img_rgba   = value[0];
      default: ;
    endcase
    reg_writes++;
  endtask

  // result checker: in-order against the oldest prediction
  always @(posedge clk_i) begin : check_results
    out_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (plot_expect_q.size() == 0) begin
        if (error_count < MAX_REPORTS)
          $display("unexpected result beat: r %02h g %02h b %02h a %02h clip %0b",
                   out_data_o.red_out, out_data_o.green_out, out_data_o.blue_out,
                   out_data_o.alpha_out, out_data_o.clipped);
        error_count++;
      end else begin
        want = plot_expect_q.pop_front();
        if (out_data_o.red_out !== want.red_out || out_data_o.green_out !== want.green_out ||
            out_data_o.blue_out !== want.blue_out ||
            out_data_o.alpha_out !== want.alpha_out ||
            out_data_o.clipped !== want.clipped) begin
          if (error_count < MAX_REPORTS)
            $display("result %0d: expected r %02h g %02h b %02h a %02h clip %0b, got r %02h g %02h b %02h a %02h clip %0b",
                     results_seen, want.red_out, want.green_out, want.blue_out,
                     want.alpha_out, want.clipped, out_data_o.red_out,
                     out_data_o.green_out, out_data_o.blue_out, out_data_o.alpha_out,
                     out_data_o.clipped);
          error_count++;
        end
        results_seen++;
      end
    end
  end

  // stimulus
  initial begin
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_wdata_i = '0;
    rst_ni      = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset size and format, extremes, unused mode, zero size
    directed_rows = '{
      row_clip(MODE_READ, 256, 0),
      row_clip(MODE_OPAQUE, 0, 256),
      row_clip(MODE_BLEND, -32768, 32767),
      row_clip(MODE_UNUSED, 32767, -1),
      row_reg(CFG_PIXEL_FORMAT, 1),
      row_known(MODE_OPAQUE, 255, 255, 'h12, 'h34, 'h56, 'h00, 'h12, 'h34, 'h56, 'hff),
      row_known(MODE_READ, 255, 255, 0, 0, 0, 0, 'h12, 'h34, 'h56, 'hff),
      row_known(MODE_OPAQUE, 0, 0, 'hff, 'hff, 'hff, 'h00, 'hff, 'hff, 'hff, 'hff),
      row_beat(MODE_BLEND, 0, 0, 'hff, 'hff, 'hff, 'hff),
      row_beat(MODE_BLEND, 0, 0, 'h10, 'h20, 'h30, 'h00),
      row_beat(MODE_UNUSED, 0, 0, 'hff, 'h00, 'hff, 'h00),
      row_known(MODE_OPAQUE, 1, 0, 0, 0, 0, 'h77, 0, 0, 0, 'hff),
      row_reg(CFG_PIXEL_FORMAT, 0),
      row_known(MODE_OPAQUE, 1, 0, 'hff, 'h00, 'h80, 'h00, 'hff, 'h00, 'h80, 'hff),
      row_known(MODE_BLEND, 1, 0, 1, 2, 3, 'hff, 1, 2, 3, 'hff),
      row_known(MODE_BLEND, 1, 0, 9, 9, 9, 'h00, 1, 2, 3, 'hff),
      row_beat(MODE_BLEND, 0, 0, 'h80, 'h40, 'hc0, 'h80),
      row_known(MODE_READ, 255, 255, 0, 0, 0, 0, 'h12, 'h34, 'h56, 'hff),
      row_reg(CFG_IMAGE_WIDTH, 1),
      row_reg(CFG_IMAGE_HEIGHT, 1),
      row_beat(MODE_READ, 0, 0, 0, 0, 0, 0),
      row_clip(MODE_OPAQUE, 1, 0),
      row_clip(MODE_BLEND, 0, 1),
      row_reg(CFG_IMAGE_WIDTH, 0),
      row_clip(MODE_OPAQUE, 0, 0),
      row_reg(CFG_IMAGE_WIDTH, 256),
      row_reg(CFG_IMAGE_HEIGHT, 256)
    };
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_REG) begin
        wait_frame_idle();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
      end else begin
        send_plot_beat(directed_rows[i].beat, directed_rows[i].known, directed_rows[i].want);
      end
    end

    // random phases, each with its own size, format and idling pattern
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_frame_idle();
      write_reg(CFG_IMAGE_WIDTH, phase_width[p]);
      write_reg(CFG_IMAGE_HEIGHT, phase_height[p]);
      write_reg(CFG_PIXEL_FORMAT, phase_format[p]);
      case (idle_mode_e'(p % 4))
        IDLE_NONE: begin
          send_gap_pct   = 0;
          recv_stall_pct = 0;
        end
        IDLE_SENDER: begin
          send_gap_pct   = 59;
          recv_stall_pct = 0;
        end
        IDLE_RECEIVER: begin
          send_gap_pct   = 0;
          recv_stall_pct = 59;
        end
        default: begin
          send_gap_pct   = 18;
          recv_stall_pct = 18;
        end
      endcase
      repeat (BEATS_PER_PHASE) send_plot_beat(draw_plot_beat(), 1'b0, '0);
    end

    wait_frame_idle();
    repeat (8) @(posedge clk_i);
    error_count += plot_expect_q.size();
    $display("pixel beats %0d (clipped %0d, blends %0d), register writes %0d",
             beats_sent, clipped_count, blend_count, reg_writes);
    $display("results checked %0d over %0d random settings, failures %0d",
             results_seen, RANDOM_PHASES, error_count);
    if (error_count == 0) begin
      $display("[pixel_plot_alpha_blend] OK");
    end else begin
      $display("[pixel_plot_alpha_blend] ERROR");
    end
    $finish;
  end

endmodule
